// File: rtl/size_class_block_allocator_core_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SCBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCBA_ASSERT(label, prop, msg)
`define SCBA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/scba_pkg.sv
package scba_pkg;

    localparam int PAGE_BYTES_DEF     = 4096;
    localparam int NUM_PAGES_DEF      = 16;
    localparam int MIN_CLASS_LOG2_DEF = 3;
    localparam int MAX_CLASS_LOG2_DEF = 11;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 12;
    localparam int BYTES_W    = 12;
    localparam int PCNT_CFG_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;
    localparam int TUSER_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 1'd1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_INIT  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NONE = 2'd1,
        STAT_ERR  = 2'd2
    } status_t;

endpackage

// File: rtl/size_class_block_allocator_core.sv
// Size-class block allocator over a region of pages.
// Requests enter on the s_ group (tuser: request kind; tdata: size, address, map grant)
// and each produces exactly one result on the m_ group (tuser: status; tdata: address,
// block bytes, page claimed, page released). Requests are handled one at a time.
// An alloc from a class list unlinks its head block; an alloc that carves a fresh page
// writes the links of every block of the page; a free that empties a page unlinks
// each block of the page with a read and two write steps on the link memories; an
// initialize sweeps over the whole page table. The link and page memories have one
// write and one read port each. An initialize latches region_start and page_count.
// Reset empties all lists and clears the latched region, so no page is managed until
// an initialize request; no clearing pass is needed. A finished result waits in the
// output register while the receiver stalls, and no new request is taken until the
// block has moved its result into the output register.
`include "size_class_block_allocator_core_macros.svh"

module size_class_block_allocator_core #(
    parameter int PAGE_BYTES     = scba_pkg::PAGE_BYTES_DEF,
    parameter int NUM_PAGES      = scba_pkg::NUM_PAGES_DEF,
    parameter int MIN_CLASS_LOG2 = scba_pkg::MIN_CLASS_LOG2_DEF,
    parameter int MAX_CLASS_LOG2 = scba_pkg::MAX_CLASS_LOG2_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // req_size[11:0], req_address[43:12], map_ok[44], zero[47:45]
    input  logic [scba_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [scba_pkg::TUSER_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_address[31:0], block_bytes[43:32], page_claimed[44], page_released[45],
    // zero[47:46]
    output logic [scba_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [scba_pkg::TUSER_W-1:0]    m_tuser,
    input  logic                            cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import scba_pkg::*;

    localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
    localparam int BPP_LOG2  = PAGE_LOG2 - MIN_CLASS_LOG2;
    localparam int BPP       = PAGE_BYTES >> MIN_CLASS_LOG2;
    localparam int NBLK      = NUM_PAGES * BPP;
    localparam int LINK_W    = $clog2(NBLK + 1);
    localparam int BADDR_W   = $clog2(NBLK);
    localparam int PG_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int PCNT_W    = $clog2(NUM_PAGES + 1);
    localparam int NCLASS    = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
    localparam int CIDX_W    = (NCLASS > 1) ? $clog2(NCLASS) : 1;
    localparam int CLS_W     = $clog2(NCLASS + 1);
    localparam int FB_W      = $clog2(BPP + 1);
    localparam int INFO_W    = CLS_W + FB_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NBLK);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_EXEC   = 16'b0000_0000_0000_0010,
        ST_INIT   = 16'b0000_0000_0000_0100,
        ST_QRY    = 16'b0000_0000_0000_1000,
        ST_SRCH   = 16'b0000_0000_0001_0000,
        ST_TH_RD  = 16'b0000_0000_0010_0000,
        ST_TH_W1  = 16'b0000_0000_0100_0000,
        ST_TH_W2  = 16'b0000_0000_1000_0000,
        ST_CARVE  = 16'b0000_0001_0000_0000,
        ST_FR_CHK = 16'b0000_0010_0000_0000,
        ST_FR_P2  = 16'b0000_0100_0000_0000,
        ST_PG_RD  = 16'b0000_1000_0000_0000,
        ST_PG_W1  = 16'b0001_0000_0000_0000,
        ST_PG_W2  = 16'b0010_0000_0000_0000,
        ST_PG_REL = 16'b0100_0000_0000_0000,
        ST_DONE   = 16'b1000_0000_0000_0000
    } state_t;

    function automatic logic [CIDX_W-1:0] class_of(input logic [31:0] s);
        logic [NCLASS-1:0] above;
        for (int j = 0; j < NCLASS; j++)
        begin
            above[j] = (j < NCLASS - 1) && ((32'd1 << (MIN_CLASS_LOG2 + j)) < s);
        end
        return CIDX_W'($countones(above));
    endfunction

    function automatic logic [FB_W-1:0] n_of(input logic [CIDX_W-1:0] c);
        if (int'(c) > BPP_LOG2)
        begin
            return '0;
        end
        return FB_W'(BPP >> c);
    endfunction

    function automatic logic [LINK_W-1:0] blk_of(input logic [PG_W-1:0] pg,
                                                 input logic [FB_W-1:0] i,
                                                 input logic [CIDX_W-1:0] c);
        logic [BPP_LOG2-1:0] in_off;
        in_off = BPP_LOG2'(32'(i) << c);
        return LINK_W'((32'(pg) << BPP_LOG2) | 32'(in_off));
    endfunction

    function automatic logic [PG_W-1:0] pg_of(input logic [LINK_W-1:0] b);
        return PG_W'(b >> BPP_LOG2);
    endfunction

    function automatic logic [BYTES_W-1:0] bytes_of(input logic [CLS_W-1:0] code);
        if (code == '0)
        begin
            return '0;
        end
        return BYTES_W'(32'd1 << (32'(MIN_CLASS_LOG2) + 32'(code) - 32'd1));
    endfunction

    state_t              state_reg, state_next;
    logic [31:0]         region_start_reg, region_start_next;
    logic [4:0]          page_count_reg, page_count_next;
    logic [31:0]         act_start_reg, act_start_next;
    logic [PCNT_W-1:0]   act_pages_reg, act_pages_next;
    req_type_t           req_type_reg, req_type_next;
    logic [SIZE_W-1:0]   req_size_reg, req_size_next;
    logic [31:0]         req_addr_reg, req_addr_next;
    logic                map_ok_reg, map_ok_next;
    logic [LINK_W-1:0]   class_head_reg [NCLASS];
    logic [LINK_W-1:0]   class_head_next [NCLASS];
    logic [LINK_W-1:0]   class_tail_reg [NCLASS];
    logic [LINK_W-1:0]   class_tail_next [NCLASS];
    logic [PG_W-1:0]     fp_head_reg, fp_head_next;
    logic [PG_W-1:0]     fp_tail_reg, fp_tail_next;
    logic [PCNT_W-1:0]   fp_len_reg, fp_len_next;
    logic [CIDX_W-1:0]   cls_reg, cls_next;
    logic [PG_W-1:0]     pg_reg, pg_next;
    logic [FB_W-1:0]     idx_reg, idx_next;
    logic [LINK_W-1:0]   blk_reg, blk_next;
    logic [LINK_W-1:0]   prv_reg, prv_next;
    logic                full_reg, full_next;
    status_t             res_st_reg, res_st_next;
    logic [31:0]         res_addr_reg, res_addr_next;
    logic [BYTES_W-1:0]  res_bytes_reg, res_bytes_next;
    logic                res_claim_reg, res_claim_next;
    logic                res_rel_reg, res_rel_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_st_reg, out_st_next;
    logic [31:0]         out_addr_reg, out_addr_next;
    logic [BYTES_W-1:0]  out_bytes_reg, out_bytes_next;
    logic                out_claim_reg, out_claim_next;
    logic                out_rel_reg, out_rel_next;

    logic                nx_we;
    logic [BADDR_W-1:0]  nx_waddr, nx_raddr;
    logic [LINK_W-1:0]   nx_wdata, nx_rdata;
    logic                pv_we;
    logic [BADDR_W-1:0]  pv_waddr, pv_raddr;
    logic [LINK_W:0]     pv_wdata, pv_rdata;
    logic                pi_we;
    logic [PG_W-1:0]     pi_waddr, pi_raddr;
    logic [INFO_W-1:0]   pi_wdata, pi_rdata;
    logic                pn_we;
    logic [PG_W-1:0]     pn_waddr, pn_raddr, pn_wdata, pn_rdata;

    logic [31:0]         off;
    logic                in_region;
    logic [PG_W-1:0]     off_pg;
    logic [BADDR_W-1:0]  off_blk;
    logic [PAGE_LOG2-1:0] off_po;
    logic [CIDX_W-1:0]   alloc_cls;
    logic                lists_ok;

    assign off       = req_addr_reg - act_start_reg;
    assign in_region = off < (32'(act_pages_reg) << PAGE_LOG2);
    assign off_pg    = off[PAGE_LOG2 +: PG_W];
    assign off_blk   = off[MIN_CLASS_LOG2 +: BADDR_W];
    assign off_po    = off[PAGE_LOG2-1:0];
    assign alloc_cls = class_of(32'(req_size_reg));

    always_comb
    begin
        lists_ok = 1'b1;
        for (int j = 0; j < NCLASS; j++)
        begin
            if ((class_head_reg[j] == NIL) != (class_tail_reg[j] == NIL))
            begin
                lists_ok = 1'b0;
            end
        end
    end

    scba_ram #(.WIDTH(LINK_W), .DEPTH(NBLK)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    scba_ram #(.WIDTH(LINK_W + 1), .DEPTH(NBLK)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    scba_ram #(.WIDTH(INFO_W), .DEPTH(NUM_PAGES)) u_info_ram (
        .clk   (clk),
        .we    (pi_we),
        .waddr (pi_waddr),
        .wdata (pi_wdata),
        .raddr (pi_raddr),
        .rdata (pi_rdata)
    );

    scba_ram #(.WIDTH(PG_W), .DEPTH(NUM_PAGES)) u_pnext_ram (
        .clk   (clk),
        .we    (pn_we),
        .waddr (pn_waddr),
        .wdata (pn_wdata),
        .raddr (pn_raddr),
        .rdata (pn_rdata)
    );

    always_comb
    begin
        logic [PCNT_W-1:0]  new_pages;
        logic [FB_W-1:0]    cur_n;
        logic [CLS_W-1:0]   fr_code;
        logic [FB_W-1:0]    fr_fb;
        logic [CIDX_W-1:0]  fr_cls;
        logic [31:0]        fr_mask;
        logic [LINK_W-1:0]  lk_n;
        logic [LINK_W-1:0]  lk_p;
        logic [LINK_W-1:0]  t_blk;

        state_next        = state_reg;
        region_start_next = region_start_reg;
        page_count_next   = page_count_reg;
        act_start_next    = act_start_reg;
        act_pages_next    = act_pages_reg;
        req_type_next     = req_type_reg;
        req_size_next     = req_size_reg;
        req_addr_next     = req_addr_reg;
        map_ok_next       = map_ok_reg;
        class_head_next   = class_head_reg;
        class_tail_next   = class_tail_reg;
        fp_head_next      = fp_head_reg;
        fp_tail_next      = fp_tail_reg;
        fp_len_next       = fp_len_reg;
        cls_next          = cls_reg;
        pg_next           = pg_reg;
        idx_next          = idx_reg;
        blk_next          = blk_reg;
        prv_next          = prv_reg;
        full_next         = full_reg;
        res_st_next       = res_st_reg;
        res_addr_next     = res_addr_reg;
        res_bytes_next    = res_bytes_reg;
        res_claim_next    = res_claim_reg;
        res_rel_next      = res_rel_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_st_next       = out_st_reg;
        out_addr_next     = out_addr_reg;
        out_bytes_next    = out_bytes_reg;
        out_claim_next    = out_claim_reg;
        out_rel_next      = out_rel_reg;

        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        nx_raddr = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = '0;
        pv_raddr = '0;
        pi_we    = 1'b0;
        pi_waddr = '0;
        pi_wdata = '0;
        pi_raddr = '0;
        pn_we    = 1'b0;
        pn_waddr = '0;
        pn_wdata = '0;
        pn_raddr = '0;

        new_pages = (32'(page_count_reg) > 32'(NUM_PAGES)) ? PCNT_W'(NUM_PAGES)
                                                          : PCNT_W'(page_count_reg);
        cur_n   = n_of(cls_reg);
        fr_code = pi_rdata[INFO_W-1 -: CLS_W];
        fr_fb   = pi_rdata[FB_W-1:0];
        fr_cls  = CIDX_W'(fr_code - CLS_W'(1));
        fr_mask = (32'd1 << (32'(MIN_CLASS_LOG2) + 32'(fr_cls))) - 32'd1;
        lk_n    = nx_rdata;
        lk_p    = pv_rdata[LINK_W-1:0];
        t_blk   = blk_of(pg_reg, idx_reg, cls_reg);

        if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_START: region_start_next = cfg_wdata;
                REG_PAGE_COUNT:   page_count_next = cfg_wdata[PCNT_CFG_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_type_next = req_type_t'(s_tuser);
                    req_size_next = s_tdata[11:0];
                    req_addr_next = s_tdata[43:12];
                    map_ok_next   = s_tdata[44];
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_st_next    = STAT_OK;
                res_addr_next  = '0;
                res_bytes_next = '0;
                res_claim_next = 1'b0;
                res_rel_next   = 1'b0;
                state_next     = ST_DONE;
                case (req_type_reg)
                    REQ_INIT:
                    begin
                        act_start_next = region_start_reg & ~32'(PAGE_BYTES - 1);
                        act_pages_next = new_pages;
                        for (int j = 0; j < NCLASS; j++)
                        begin
                            class_head_next[j] = NIL;
                            class_tail_next[j] = NIL;
                        end
                        fp_head_next = '0;
                        fp_tail_next = PG_W'(new_pages - PCNT_W'(1));
                        fp_len_next  = new_pages;
                        pg_next      = '0;
                        state_next   = ST_INIT;
                    end
                    REQ_QUERY:
                    begin
                        if (!in_region)
                        begin
                            res_st_next = STAT_ERR;
                        end
                        else
                        begin
                            pi_raddr   = off_pg;
                            state_next = ST_QRY;
                        end
                    end
                    REQ_ALLOC:
                    begin
                        if (32'(req_size_reg) > (32'd1 << MAX_CLASS_LOG2))
                        begin
                            res_st_next = STAT_ERR;
                        end
                        else if (req_size_reg == '0)
                        begin
                            res_st_next = STAT_NONE;
                        end
                        else
                        begin
                            cls_next = alloc_cls;
                            if (class_head_reg[alloc_cls] != NIL)
                            begin
                                state_next = ST_TH_RD;
                            end
                            else if (fp_len_reg != '0)
                            begin
                                if (!map_ok_reg || n_of(alloc_cls) == '0)
                                begin
                                    res_st_next = STAT_NONE;
                                end
                                else
                                begin
                                    pg_next        = fp_head_reg;
                                    pn_raddr       = fp_head_reg;
                                    fp_len_next    = fp_len_reg - PCNT_W'(1);
                                    idx_next       = '0;
                                    res_addr_next  = act_start_reg
                                                   + (32'(fp_head_reg) << PAGE_LOG2);
                                    res_claim_next = 1'b1;
                                    state_next     = ST_CARVE;
                                end
                            end
                            else if (alloc_cls == CIDX_W'(NCLASS - 1))
                            begin
                                res_st_next = STAT_NONE;
                            end
                            else
                            begin
                                cls_next   = alloc_cls + CIDX_W'(1);
                                state_next = ST_SRCH;
                            end
                        end
                    end
                    REQ_FREE:
                    begin
                        if (!in_region)
                        begin
                            res_st_next = STAT_ERR;
                        end
                        else
                        begin
                            pg_next    = off_pg;
                            blk_next   = LINK_W'(off_blk);
                            pi_raddr   = off_pg;
                            pv_raddr   = off_blk;
                            state_next = ST_FR_CHK;
                        end
                    end
                    default:
                    begin
                        res_st_next = STAT_ERR;
                    end
                endcase
            end
            ST_INIT:
            begin
                pi_we    = 1'b1;
                pi_waddr = pg_reg;
                pi_wdata = '0;
                pn_we    = 1'b1;
                pn_waddr = pg_reg;
                pn_wdata = pg_reg + PG_W'(1);
                if (pg_reg == PG_W'(NUM_PAGES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pg_next = pg_reg + PG_W'(1);
                end
            end
            ST_QRY:
            begin
                res_bytes_next = bytes_of(fr_code);
                state_next     = ST_DONE;
            end
            ST_SRCH:
            begin
                if (class_head_reg[cls_reg] != NIL)
                begin
                    state_next = ST_TH_RD;
                end
                else if (cls_reg == CIDX_W'(NCLASS - 1))
                begin
                    res_st_next = STAT_NONE;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cls_next = cls_reg + CIDX_W'(1);
                end
            end
            ST_TH_RD:
            begin
                blk_next   = class_head_reg[cls_reg];
                nx_raddr   = class_head_reg[cls_reg][BADDR_W-1:0];
                pi_raddr   = pg_of(class_head_reg[cls_reg]);
                state_next = ST_TH_W1;
            end
            ST_TH_W1:
            begin
                class_head_next[cls_reg] = lk_n;
                if (lk_n == NIL)
                begin
                    class_tail_next[cls_reg] = NIL;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = lk_n[BADDR_W-1:0];
                    pv_wdata = {1'b1, NIL};
                end
                pi_we      = 1'b1;
                pi_waddr   = pg_of(blk_reg);
                pi_wdata   = {fr_code, fr_fb - FB_W'(1)};
                state_next = ST_TH_W2;
            end
            ST_TH_W2:
            begin
                pv_we         = 1'b1;
                pv_waddr      = blk_reg[BADDR_W-1:0];
                pv_wdata      = {1'b0, NIL};
                res_addr_next = act_start_reg + (32'(blk_reg) << MIN_CLASS_LOG2);
                state_next    = ST_DONE;
            end
            ST_CARVE:
            begin
                if (idx_reg == '0)
                begin
                    if (fp_len_reg != '0)
                    begin
                        fp_head_next = pn_rdata;
                    end
                    pi_we    = 1'b1;
                    pi_waddr = pg_reg;
                    pi_wdata = {CLS_W'(cls_reg) + CLS_W'(1), cur_n - FB_W'(1)};
                    if (cur_n > FB_W'(1))
                    begin
                        class_head_next[cls_reg] = blk_of(pg_reg, FB_W'(1), cls_reg);
                        class_tail_next[cls_reg] = blk_of(pg_reg, cur_n - FB_W'(1), cls_reg);
                    end
                    else
                    begin
                        class_head_next[cls_reg] = NIL;
                        class_tail_next[cls_reg] = NIL;
                    end
                end
                nx_we    = 1'b1;
                nx_waddr = t_blk[BADDR_W-1:0];
                pv_we    = 1'b1;
                pv_waddr = t_blk[BADDR_W-1:0];
                if (idx_reg == '0 || idx_reg == cur_n - FB_W'(1))
                begin
                    nx_wdata = NIL;
                end
                else
                begin
                    nx_wdata = blk_of(pg_reg, idx_reg + FB_W'(1), cls_reg);
                end
                if (idx_reg == '0)
                begin
                    pv_wdata = {1'b0, NIL};
                end
                else if (idx_reg == FB_W'(1))
                begin
                    pv_wdata = {1'b1, NIL};
                end
                else
                begin
                    pv_wdata = {1'b1, blk_of(pg_reg, idx_reg - FB_W'(1), cls_reg)};
                end
                if (idx_reg == cur_n - FB_W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + FB_W'(1);
                end
            end
            ST_FR_CHK:
            begin
                if (fr_code == '0 || (32'(off_po) & fr_mask) != '0 || pv_rdata[LINK_W])
                begin
                    res_st_next = STAT_ERR;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cls_next = fr_cls;
                    nx_we    = 1'b1;
                    nx_waddr = blk_reg[BADDR_W-1:0];
                    nx_wdata = NIL;
                    pv_we    = 1'b1;
                    pv_waddr = blk_reg[BADDR_W-1:0];
                    pv_wdata = {1'b1, class_tail_reg[fr_cls]};
                    if (class_tail_reg[fr_cls] == NIL)
                    begin
                        class_head_next[fr_cls] = blk_reg;
                    end
                    class_tail_next[fr_cls] = blk_reg;
                    pi_we     = 1'b1;
                    pi_waddr  = pg_reg;
                    pi_wdata  = {fr_code, fr_fb + FB_W'(1)};
                    full_next = (fr_fb + FB_W'(1)) == n_of(fr_cls);
                    prv_next  = class_tail_reg[fr_cls];
                    idx_next  = '0;
                    if (class_tail_reg[fr_cls] != NIL)
                    begin
                        state_next = ST_FR_P2;
                    end
                    else if ((fr_fb + FB_W'(1)) == n_of(fr_cls))
                    begin
                        state_next = ST_PG_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FR_P2:
            begin
                nx_we      = 1'b1;
                nx_waddr   = prv_reg[BADDR_W-1:0];
                nx_wdata   = blk_reg;
                state_next = full_reg ? ST_PG_RD : ST_DONE;
            end
            ST_PG_RD:
            begin
                blk_next   = t_blk;
                nx_raddr   = t_blk[BADDR_W-1:0];
                pv_raddr   = t_blk[BADDR_W-1:0];
                state_next = ST_PG_W1;
            end
            ST_PG_W1:
            begin
                if (lk_p == NIL)
                begin
                    class_head_next[cls_reg] = lk_n;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = lk_p[BADDR_W-1:0];
                    nx_wdata = lk_n;
                end
                if (lk_n == NIL)
                begin
                    class_tail_next[cls_reg] = lk_p;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = lk_n[BADDR_W-1:0];
                    pv_wdata = {1'b1, lk_p};
                end
                prv_next   = lk_p;
                state_next = ST_PG_W2;
            end
            ST_PG_W2:
            begin
                pv_we    = 1'b1;
                pv_waddr = blk_reg[BADDR_W-1:0];
                pv_wdata = {1'b0, prv_reg};
                if (idx_reg == cur_n - FB_W'(1))
                begin
                    state_next = ST_PG_REL;
                end
                else
                begin
                    idx_next   = idx_reg + FB_W'(1);
                    state_next = ST_PG_RD;
                end
            end
            ST_PG_REL:
            begin
                pi_we    = 1'b1;
                pi_waddr = pg_reg;
                pi_wdata = '0;
                if (fp_len_reg == '0)
                begin
                    fp_head_next = pg_reg;
                end
                else
                begin
                    pn_we    = 1'b1;
                    pn_waddr = fp_tail_reg;
                    pn_wdata = pg_reg;
                end
                fp_tail_next  = pg_reg;
                fp_len_next   = fp_len_reg + PCNT_W'(1);
                res_addr_next = act_start_reg + (32'(pg_reg) << PAGE_LOG2);
                res_rel_next  = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_addr_next  = res_addr_reg;
                    out_bytes_next = res_bytes_reg;
                    out_claim_next = res_claim_reg;
                    out_rel_next   = res_rel_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            region_start_reg <= '0;
            page_count_reg   <= '0;
            act_start_reg    <= '0;
            act_pages_reg    <= '0;
            for (int j = 0; j < NCLASS; j++)
            begin
                class_head_reg[j] <= NIL;
                class_tail_reg[j] <= NIL;
            end
            fp_head_reg      <= '0;
            fp_tail_reg      <= '0;
            fp_len_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            region_start_reg <= region_start_next;
            page_count_reg   <= page_count_next;
            act_start_reg    <= act_start_next;
            act_pages_reg    <= act_pages_next;
            class_head_reg   <= class_head_next;
            class_tail_reg   <= class_tail_next;
            fp_head_reg      <= fp_head_next;
            fp_tail_reg      <= fp_tail_next;
            fp_len_reg       <= fp_len_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        req_size_reg  <= req_size_next;
        req_addr_reg  <= req_addr_next;
        map_ok_reg    <= map_ok_next;
        cls_reg       <= cls_next;
        pg_reg        <= pg_next;
        idx_reg       <= idx_next;
        blk_reg       <= blk_next;
        prv_reg       <= prv_next;
        full_reg      <= full_next;
        res_st_reg    <= res_st_next;
        res_addr_reg  <= res_addr_next;
        res_bytes_reg <= res_bytes_next;
        res_claim_reg <= res_claim_next;
        res_rel_reg   <= res_rel_next;
        out_st_reg    <= out_st_next;
        out_addr_reg  <= out_addr_next;
        out_bytes_reg <= out_bytes_next;
        out_claim_reg <= out_claim_next;
        out_rel_reg   <= out_rel_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tdata  = {2'b00, out_rel_reg, out_claim_reg, out_bytes_reg, out_addr_reg};

    `SCBA_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, state_reg == ST_EXEC, "request not executed after acceptance")
    `SCBA_ASSERT(a_fp_len, fp_len_reg <= act_pages_reg, "free page count exceeds managed pages")
    `SCBA_ASSERT(a_claim_rel, !(m_tvalid && out_claim_reg && out_rel_reg), "result both claims and releases a page")
    `SCBA_ASSERT(a_lists, (state_reg != ST_IDLE) || lists_ok, "class list head and tail disagree on emptiness")

endmodule

// File: rtl/scba_ram.sv
module scba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: test/size_class_block_allocator_core_tb.sv
`timescale 1ns / 100ps

module size_class_block_allocator_core_tb;
    import scba_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [31:0] address;
        logic [11:0] block_bytes;
        logic        page_claimed;
        logic        page_released;
    } alloc_result_t;

    class alloc_scoreboard;
        localparam int BLK_PER_PAGE = 512;
        localparam int NO_BLOCK = 8192;
        localparam int NUM_CLASSES = 9;

        logic [31:0] reg_start;
        logic [4:0] reg_pages;
        logic [31:0] base;
        int pages;
        int class_bytes[16];
        int free_blocks[16];
        int page_next[16];
        int page_head;
        int page_tail;
        int page_len;
        int next_blk[8192];
        int prev_blk[8192];
        bit blk_free[8192];
        int list_head[9];
        int list_tail[9];
        alloc_result_t pending[$];
        logic [31:0] live_blocks[$];
        int errors;
        int n_alloc;
        int n_free;
        int n_claim;
        int n_release;

        function new();
            errors = 0;
            n_alloc = 0;
            n_free = 0;
            n_claim = 0;
            n_release = 0;
            reg_start = 0;
            reg_pages = 0;
            base = 0;
            pages = 0;
            clear_state();
        endfunction

        function void clear_state();
            for (int i = 0; i < 16; i++)
            begin
                class_bytes[i] = 0;
                free_blocks[i] = 0;
                page_next[i] = 0;
            end
            for (int i = 0; i < 8192; i++)
            begin
                next_blk[i] = 0;
                prev_blk[i] = 0;
                blk_free[i] = 0;
            end
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                list_head[c] = NO_BLOCK;
                list_tail[c] = NO_BLOCK;
            end
            page_head = 0;
            page_tail = 0;
            page_len = 0;
            live_blocks.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_REGION_START)
                reg_start = value;
            else
                reg_pages = value[4:0];
        endfunction

        function void append_block(int c, int b);
            int t;
            t = list_tail[c];
            next_blk[b] = NO_BLOCK;
            prev_blk[b] = t;
            if (t == NO_BLOCK)
                list_head[c] = b;
            else
                next_blk[t] = b;
            list_tail[c] = b;
            blk_free[b] = 1;
        endfunction

        function void remove_block(int c, int b);
            int p;
            int n;
            p = prev_blk[b];
            n = next_blk[b];
            if (p == NO_BLOCK)
                list_head[c] = n;
            else
                next_blk[p] = n;
            if (n == NO_BLOCK)
                list_tail[c] = p;
            else
                prev_blk[n] = p;
            blk_free[b] = 0;
        endfunction

        function void append_page(int pg);
            if (page_len == 0)
                page_head = pg;
            else
                page_next[page_tail] = pg;
            page_tail = pg;
            page_len++;
        endfunction

        function int class_of(int s);
            int c;
            c = 0;
            while (c + 1 < NUM_CLASSES && (1 << (3 + c)) < s)
                c++;
            return c;
        endfunction

        function logic [31:0] pop_block(int c);
            int b;
            logic [31:0] a;
            b = list_head[c];
            remove_block(c, b);
            free_blocks[b / BLK_PER_PAGE]--;
            a = base + 32'((b / BLK_PER_PAGE) * 4096) + 32'((b % BLK_PER_PAGE) << 3);
            live_blocks.push_back(a);
            n_alloc++;
            return a;
        endfunction

        function void note_request(req_type_t kind, logic [11:0] size, logic [31:0] addr,
                                   logic map_ok);
            alloc_result_t r;
            logic [31:0] off;
            logic [31:0] span;
            bit in_region;
            int c;
            int s;
            int n;
            int pg;
            int po;
            int b;
            int k;
            r = '0;
            r.status = STAT_OK;
            off = addr - base;
            span = 32'(pages * 4096);
            in_region = off < span;
            case (kind)
                REQ_INIT:
                begin
                    clear_state();
                    base = {reg_start[31:12], 12'h000};
                    pages = (reg_pages > 16) ? 16 : int'(reg_pages);
                    for (int p = 0; p < pages; p++)
                        append_page(p);
                end
                REQ_QUERY:
                begin
                    if (!in_region)
                        r.status = STAT_ERR;
                    else
                        r.block_bytes = 12'(class_bytes[off / 4096]);
                end
                REQ_ALLOC:
                begin
                    if (size > 2048)
                        r.status = STAT_ERR;
                    else if (size == 0)
                        r.status = STAT_NONE;
                    else
                    begin
                        c = class_of(size);
                        s = 1 << (3 + c);
                        if (list_head[c] != NO_BLOCK)
                            r.address = pop_block(c);
                        else if (page_len != 0)
                        begin
                            n = 4096 / s;
                            if (!map_ok || n == 0)
                                r.status = STAT_NONE;
                            else
                            begin
                                pg = page_head;
                                page_len--;
                                if (page_len != 0)
                                    page_head = page_next[pg];
                                class_bytes[pg] = s;
                                for (int i = 0; i < n; i++)
                                    append_block(c, pg * BLK_PER_PAGE + i * (s >> 3));
                                free_blocks[pg] = n;
                                r.address = pop_block(c);
                                r.page_claimed = 1;
                                n_claim++;
                            end
                        end
                        else
                        begin
                            k = c + 1;
                            while (k < NUM_CLASSES && list_head[k] == NO_BLOCK)
                                k++;
                            if (k < NUM_CLASSES)
                                r.address = pop_block(k);
                            else
                                r.status = STAT_NONE;
                        end
                    end
                end
                default:
                begin
                    if (!in_region)
                        r.status = STAT_ERR;
                    else
                    begin
                        pg = off / 4096;
                        po = off % 4096;
                        s = class_bytes[pg];
                        b = pg * BLK_PER_PAGE + (po >> 3);
                        if (s == 0 || (po % s) != 0 || blk_free[b])
                            r.status = STAT_ERR;
                        else
                        begin
                            c = class_of(s);
                            append_block(c, b);
                            free_blocks[pg]++;
                            n_free++;
                            for (int i = 0; i < live_blocks.size(); i++)
                                if (live_blocks[i] == addr)
                                begin
                                    live_blocks.delete(i);
                                    break;
                                end
                            if (free_blocks[pg] == 4096 / s)
                            begin
                                n = 4096 / s;
                                for (int i = 0; i < n; i++)
                                    remove_block(c, pg * BLK_PER_PAGE + i * (s >> 3));
                                class_bytes[pg] = 0;
                                free_blocks[pg] = 0;
                                append_page(pg);
                                r.address = base + 32'(pg * 4096);
                                r.page_released = 1;
                                n_release++;
                            end
                        end
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [47:0] data);
            alloc_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no request outstanding: status %0d data %h",
                         $realtime, status, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
                errors++;
            end
            if (data[31:0] !== e.address)
            begin
                $display("%0t: address expected %h actual %h", $realtime, e.address,
                         data[31:0]);
                errors++;
            end
            if (data[43:32] !== e.block_bytes)
            begin
                $display("%0t: block bytes expected %0d actual %0d", $realtime,
                         e.block_bytes, data[43:32]);
                errors++;
            end
            if (data[44] !== e.page_claimed)
            begin
                $display("%0t: page claimed expected %b actual %b", $realtime,
                         e.page_claimed, data[44]);
                errors++;
            end
            if (data[45] !== e.page_released)
            begin
                $display("%0t: page released expected %b actual %b", $realtime,
                         e.page_released, data[45]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    alloc_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    size_class_block_allocator_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, quiet_cycles);
            $display("[size_class_block_allocator_core] ERROR");
            $finish;
        end
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = 400;
        end
        if (!rst_n)
            m_tready <= 0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_request(req_type_t kind, logic [11:0] size, logic [31:0] addr,
                                logic map_ok);
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {3'b000, map_ok, addr, size};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, size, addr, map_ok);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic setup_region(logic [31:0] start, logic [4:0] count);
        wait_drained();
        write_reg(REG_REGION_START, start);
        write_reg(REG_PAGE_COUNT, 32'(count));
        cfg_we <= 0;
        send_request(REQ_INIT, 12'($urandom), $urandom, 1'($urandom));
    endtask

    function automatic logic [11:0] pick_size();
        int k;
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 12'd0;
        if (r < 7)
            return 12'($urandom_range(4095, 2049));
        k = $urandom_range(8);
        if (k == 0)
            return 12'($urandom_range(8, 1));
        return 12'($urandom_range(8 << k, (4 << k) + 1));
    endfunction

    function automatic logic [31:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (sb.live_blocks.size() != 0 && r < 75)
            return sb.live_blocks[$urandom_range(sb.live_blocks.size() - 1)];
        if (r < 90)
            return sb.base + 32'($urandom_range(sb.pages * 4096 + 64)) - 32'd16;
        return $urandom;
    endfunction

    task automatic random_request();
        int r;
        logic map_ok;
        r = $urandom_range(99);
        map_ok = ($urandom_range(99) < 90);
        if (r < 45)
            send_request(REQ_ALLOC, pick_size(), $urandom, map_ok);
        else if (r < 85)
            send_request(REQ_FREE, 12'($urandom), pick_address(), map_ok);
        else if (r < 98)
            send_request(REQ_QUERY, 12'($urandom), pick_address(), map_ok);
        else
            send_request(REQ_INIT, 12'($urandom), $urandom, map_ok);
    endtask

    initial
    begin
        logic [31:0] starts [6];
        logic [4:0] counts [6];
        starts = '{32'h0000_0000, 32'hFFFF_F000, 32'h8000_0ABC, 32'h0, 32'h0, 32'h0};
        counts = '{5'd16, 5'd16, 5'd1, 5'd31, 5'd3, 5'd17};
        starts[3] = $urandom;
        starts[4] = $urandom;
        starts[5] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Nothing is managed before the first initialize.
        send_request(REQ_ALLOC, 12'd16, 32'h0, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h0, 1'b1);
        send_request(REQ_QUERY, 12'd0, 32'h0, 1'b1);
        setup_region(32'h1234_5FFF, 5'd2);
        send_request(REQ_ALLOC, 12'd0, 32'h0, 1'b1);
        send_request(REQ_ALLOC, 12'd4095, 32'h0, 1'b1);
        send_request(REQ_ALLOC, 12'd2049, 32'h0, 1'b1);
        send_request(REQ_ALLOC, 12'd1, 32'h0, 1'b0);
        send_request(REQ_ALLOC, 12'd1, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_ALLOC, 12'd8, 32'h0, 1'b0);
        send_request(REQ_ALLOC, 12'd2048, 32'h0, 1'b1);
        send_request(REQ_ALLOC, 12'd100, 32'h0, 1'b1);
        send_request(REQ_ALLOC, 12'd2048, 32'h0, 1'b1);
        send_request(REQ_QUERY, 12'd0, 32'h1234_5000, 1'b1);
        send_request(REQ_QUERY, 12'd0, 32'h1234_6800, 1'b1);
        send_request(REQ_QUERY, 12'd0, 32'h1234_7000, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_5004, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_4FF8, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_5008, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_5008, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_5000, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_6000, 1'b1);
        send_request(REQ_FREE, 12'd0, 32'h1234_6800, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            setup_region(starts[ph], counts[ph]);
            tx_idle_pct = (ph % 4 == 1) ? 74 : (ph % 4 == 3) ? 12 : 0;
            rx_stall_pct = (ph % 4 == 2) ? 74 : (ph % 4 == 3) ? 12 : 0;
            for (int i = 0; i < 125; i++)
            begin
                if (ph == 0 && i == 40)
                    hold_request = 1;
                random_request();
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Covered %0d allocations, %0d frees, %0d page claims, %0d page releases",
                 sb.n_alloc, sb.n_free, sb.n_claim, sb.n_release);
        $display("over six region settings and four idling patterns.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[size_class_block_allocator_core] OK");
        else
            $display("[size_class_block_allocator_core] ERROR");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/size_class_block_allocator_core.sv
test/size_class_block_allocator_core_tb.sv
